[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF      = 16384;
  localparam int MIN_SPLIT_BYTES_DEF = 16;
  localparam int PTR_W               = 14;
  localparam int CHUNK_W             = 15;
  localparam int OFF_W               = 16;   // byte offsets and block sizes
  localparam int WORD_W              = 32;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 15'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_IGN = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;

  localparam logic [1:0] CMD_NULL  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [PTR_W-1:0] request_bytes;
    logic [PTR_W-1:0] block_pointer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PTR_W-1:0] result_pointer;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OFF_W-1:0] need;
    logic [PTR_W-1:0] ptr;
  } cmd_t;

  // Header or footer word: size with the low three bits replaced by the flag.
  function automatic logic [WORD_W-1:0] pack_word(input logic [OFF_W-1:0] size,
                                                  input logic alloc);
    pack_word = {16'b0, size[OFF_W-1:3], 2'b00, alloc};
  endfunction

endpackage

[rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an implicit free list with header/footer words.
// ----------------------------------------------------------------------------
// Once the engine takes a word, a null request is answered; an allocate walks the
// headers, then writes a whole or split block, growing the heap first when no
// block fits, or answers out of memory; a free walks the headers, then writes the
// header and footer. One item at a time is in the engine, so the header walk sets
// the rate while results are taken. After reset it writes prologue and epilogue.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES      = HEAP_BYTES_DEF,
  parameter int MIN_SPLIT_BYTES = MIN_SPLIT_BYTES_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CHUNK_W-1:0] cfg_data
);

  logic [CHUNK_W-1:0] chunk_r;
  logic               q_valid, q_pop;
  cmd_t               q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= CHUNK_RESET;
    end else if (cfg_valid) begin
      chunk_r <= cfg_data;
    end
  end

  ffha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  ffha_back #(
    .HEAP_BYTES      (HEAP_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .chunk     (chunk_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A word that is not a success never carries a pointer.
  a_ptr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_pointer == '0)
    else $error("nonzero pointer on failed request");

  // Payload offsets handed out are 8-byte aligned.
  a_ptr_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_pointer[2:0] == 3'b000)
    else $error("misaligned payload pointer");

  // The status code 3 is never produced.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

endmodule

[rtl/ffha_front.sv]
// ----------------------------------------------------------------------------
// ffha_front
// Accepts request words, sorts them into null, allocate and free commands,
// pads allocate sizes and queues the commands for the heap engine.
// ----------------------------------------------------------------------------
module ffha_front
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_data,
  input  logic     q_pop
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    cmd.ptr  = in_data.block_pointer;
    cmd.need = (in_data.request_bytes <= 14'd8) ? 16'd16 :
               ((OFF_W'(in_data.request_bytes) + 16'd15) & ~16'd7);
    if (in_data.operation == OP_ALLOC) begin
      cmd.kind = (in_data.request_bytes == '0) ? CMD_NULL : CMD_ALLOC;
    end else begin
      cmd.kind = (in_data.block_pointer == '0) ? CMD_NULL : CMD_FREE;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

[rtl/ffha_back.sv]
// ----------------------------------------------------------------------------
// ffha_back
// Heap engine: owns the heap memory, walks the block chain one header at a
// time, splits, extends and frees blocks, and holds the result word.
// ----------------------------------------------------------------------------
module ffha_back
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES      = HEAP_BYTES_DEF,
  parameter int MIN_SPLIT_BYTES = MIN_SPLIT_BYTES_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CHUNK_W-1:0] chunk,
  input  logic               q_valid,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  localparam int MEM_WORDS  = HEAP_BYTES / 4;
  localparam int AW         = $clog2(MEM_WORDS);
  localparam int HEAP_LIMIT = (HEAP_BYTES < 16383) ? HEAP_BYTES : 16383;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_CHK = 4'd3;
  localparam logic [3:0] S_EXT0  = 4'd4;
  localparam logic [3:0] S_EXT1  = 4'd5;
  localparam logic [3:0] S_P_SET = 4'd6;
  localparam logic [3:0] S_P_WR  = 4'd7;
  localparam logic [3:0] S_F_RD  = 4'd8;
  localparam logic [3:0] S_F_CHK = 4'd9;
  localparam logic [3:0] S_F_FTR = 4'd10;

  logic [WORD_W-1:0] mem [MEM_WORDS];

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       init_r, init_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [OFF_W-1:0] bp_r, bp_nxt;
  logic [OFF_W-1:0] need_r, need_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [OFF_W-1:0] have_r, have_nxt;
  logic [OFF_W-1:0] rest_r, rest_nxt;
  logic [OFF_W-1:0] ext_r, ext_nxt;
  logic [OFF_W-1:0] ep_r, ep_nxt;
  logic [WORD_W-1:0] rdata_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic              we, re;
  logic [OFF_W-1:0]  wr_off, rd_off;
  logic [WORD_W-1:0] wr_data;
  logic [OFF_W-1:0]  sz, mark, chunk8;
  logic              split;
  logic [OFF_W:0]    ext_end;

  assign sz      = {rdata_r[OFF_W-1:3], 3'b000};
  assign split   = (rest_r >= OFF_W'(MIN_SPLIT_BYTES));
  assign mark    = split ? need_r : have_r;
  assign chunk8  = OFF_W'({chunk[CHUNK_W-1:3], 3'b000});
  assign ext_end = {1'b0, ep_r} + {1'b0, ext_r};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    step_nxt      = step_r;
    bp_nxt        = bp_r;
    need_nxt      = need_r;
    ptr_nxt       = ptr_r;
    have_nxt      = have_r;
    rest_nxt      = rest_r;
    ext_nxt       = ext_r;
    ep_nxt        = ep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wr_off        = '0;
    wr_data       = '0;
    re            = 1'b0;
    rd_off        = '0;

    unique case (state_r)
      S_INIT: begin
        // Lay down the prologue header, prologue footer and epilogue.
        we       = 1'b1;
        wr_off   = OFF_W'({init_r, 2'b00}) + 16'd4;
        wr_data  = (init_r == 2'd2) ? pack_word(16'd0, 1'b1) : pack_word(16'd8, 1'b1);
        init_nxt = init_r + 2'd1;
        if (init_r == 2'd2) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop    = 1'b1;
          need_nxt = q_data.need;
          ptr_nxt  = q_data.ptr;
          if (q_data.kind == CMD_ALLOC) begin
            bp_nxt    = 16'd8;
            state_nxt = S_A_RD;
          end else if (q_data.kind == CMD_FREE) begin
            bp_nxt    = 16'd16;
            state_nxt = S_F_RD;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ST_IGN, result_pointer: '0};
          end
        end
      end
      S_A_RD: begin
        if (bp_r >= ep_r) begin
          state_nxt = S_EXT0;
        end else begin
          re        = 1'b1;
          rd_off    = bp_r - 16'd4;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sz == '0) begin
          state_nxt = S_EXT0;
        end else if (!rdata_r[0] && sz >= need_r) begin
          have_nxt  = sz;
          state_nxt = S_P_SET;
        end else begin
          bp_nxt    = bp_r + sz;
          state_nxt = S_A_RD;
        end
      end
      S_EXT0: begin
        ext_nxt   = (chunk8 < need_r) ? need_r : chunk8;
        state_nxt = S_EXT1;
      end
      S_EXT1: begin
        if (ext_end > (OFF_W+1)'(HEAP_LIMIT)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OOM, result_pointer: '0};
          state_nxt     = S_IDLE;
        end else begin
          // New epilogue; the new block's own marks come from the placement.
          we        = 1'b1;
          wr_off    = ext_end[OFF_W-1:0] - 16'd4;
          wr_data   = pack_word(16'd0, 1'b1);
          ep_nxt    = ext_end[OFF_W-1:0];
          bp_nxt    = ep_r;
          have_nxt  = ext_r;
          state_nxt = S_P_SET;
        end
      end
      S_P_SET: begin
        rest_nxt  = have_r - need_r;
        step_nxt  = 2'd0;
        state_nxt = S_P_WR;
      end
      S_P_WR: begin
        we = 1'b1;
        unique case (step_r)
          2'd0: begin
            wr_off  = bp_r - 16'd4;
            wr_data = pack_word(mark, 1'b1);
          end
          2'd1: begin
            wr_off  = bp_r + mark - 16'd8;
            wr_data = pack_word(mark, 1'b1);
          end
          2'd2: begin
            wr_off  = bp_r + mark - 16'd4;
            wr_data = pack_word(rest_r, 1'b0);
          end
          default: begin
            wr_off  = bp_r + have_r - 16'd8;
            wr_data = pack_word(rest_r, 1'b0);
          end
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == (split ? 2'd3 : 2'd1)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, result_pointer: bp_r[PTR_W-1:0]};
          state_nxt     = S_IDLE;
        end
      end
      S_F_RD: begin
        if (bp_r >= ep_r || bp_r > OFF_W'(ptr_r)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_IGN, result_pointer: '0};
          state_nxt     = S_IDLE;
        end else begin
          re        = 1'b1;
          rd_off    = bp_r - 16'd4;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sz == '0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_IGN, result_pointer: '0};
          state_nxt     = S_IDLE;
        end else if (bp_r == OFF_W'(ptr_r)) begin
          we        = 1'b1;
          wr_off    = bp_r - 16'd4;
          wr_data   = pack_word(sz, 1'b0);
          have_nxt  = sz;
          state_nxt = S_F_FTR;
        end else begin
          bp_nxt    = bp_r + sz;
          state_nxt = S_F_RD;
        end
      end
      S_F_FTR: begin
        we            = 1'b1;
        wr_off        = bp_r + have_r - 16'd8;
        wr_data       = pack_word(have_r, 1'b0);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_OK, result_pointer: '0};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= 2'd0;
      ep_r        <= 16'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      ep_r        <= ep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    bp_r       <= bp_nxt;
    need_r     <= need_nxt;
    ptr_r      <= ptr_nxt;
    have_r     <= have_nxt;
    rest_r     <= rest_nxt;
    ext_r      <= ext_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(wr_off[OFF_W-1:2])] <= wr_data;
    end
    if (re) begin
      rdata_r <= mem[AW'(rd_off[OFF_W-1:2])];
    end
  end

endmodule
